@@ rtl/rlc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants of the rectangle line clipper.
// ----------------------------------------------------------------------------
package rlc_pkg;

   localparam int COORD_W = 12;
   localparam int CSR_AW  = 2;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic [1:0] clip_status;
      coord_type  clip_start_x;
      coord_type  clip_start_y;
      coord_type  clip_end_x;
      coord_type  clip_end_y;
   } rsp_type;

   typedef struct packed {
      coord_type xmin;
      coord_type xmax;
      coord_type ymin;
      coord_type ymax;
   } window_type;

   // Crossing parameter n / d with d > 0.
   typedef struct packed {
      logic signed [COORD_W:0] n;
      logic [COORD_W-1:0]      d;
   } frac_type;

   typedef struct packed {
      logic     rej;
      frac_type enter;
      frac_type leave;
   } axis_type;

   // One classified segment as it waits in the queue.
   typedef struct packed {
      logic     rej;
      frac_type ex;
      frac_type ey;
      frac_type lx;
      frac_type ly;
      req_type  seg;
   } task_type;

   localparam logic [1:0] ST_REJECT = 2'd0;
   localparam logic [1:0] ST_INSIDE = 2'd1;
   localparam logic [1:0] ST_CLIPPED = 2'd2;

   localparam logic [CSR_AW-1:0] REG_XMIN = 2'd0;
   localparam logic [CSR_AW-1:0] REG_XMAX = 2'd1;
   localparam logic [CSR_AW-1:0] REG_YMIN = 2'd2;
   localparam logic [CSR_AW-1:0] REG_YMAX = 2'd3;

   localparam coord_type RST_XMIN = -12'sd100;
   localparam coord_type RST_XMAX = 12'sd100;
   localparam coord_type RST_YMIN = -12'sd80;
   localparam coord_type RST_YMAX = 12'sd80;

   function automatic logic signed [COORD_W:0] sext1(input coord_type v);
      sext1 = {v[COORD_W-1], v};
   endfunction

endpackage

@@ rtl/rlc_front.sv @@
// ----------------------------------------------------------------------------
// rlc_front
// Classifies each segment: parallel-slab rejection and the entering and
// leaving crossing parameter of each axis.
// ----------------------------------------------------------------------------
module rlc_front import rlc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  req_type    in_data,
   input  window_type win,
   output logic       out_valid,
   output task_type   out_task
);

   localparam int W = COORD_W;

   logic     valid_ff;
   task_type task_ff;
   task_type task_in;
   axis_type ax;
   axis_type ay;

   function automatic axis_type classify(input coord_type p0, input coord_type p1,
                                         input coord_type lo, input coord_type hi);
      logic signed [W:0] dlt;
      logic signed [W:0] ndlt;
      logic signed [W:0] qlo;
      logic signed [W:0] qhi;
      axis_type a;
      dlt  = sext1(p1) - sext1(p0);
      ndlt = -dlt;
      qlo  = sext1(lo) - sext1(p0);
      qhi  = sext1(hi) - sext1(p0);
      a.rej         = 1'b0;
      a.enter.n     = '0;
      a.enter.d     = W'(1);
      a.leave.n     = (W+1)'(1);
      a.leave.d     = W'(1);
      if (dlt == '0) begin
         a.rej = (qhi < 0) || (qlo > 0);
      end else if (dlt > 0) begin
         a.enter.n = qlo;
         a.enter.d = dlt[W-1:0];
         a.leave.n = qhi;
         a.leave.d = dlt[W-1:0];
      end else begin
         a.enter.n = -qhi;
         a.enter.d = ndlt[W-1:0];
         a.leave.n = -qlo;
         a.leave.d = ndlt[W-1:0];
      end
      // Entering values at or below zero never beat the start value of zero;
      // leaving values at or above one never beat one.
      if (a.enter.n <= 0) begin
         a.enter.n = '0;
         a.enter.d = W'(1);
      end
      if (a.leave.n >= $signed({1'b0, a.leave.d})) begin
         a.leave.n = (W+1)'(1);
         a.leave.d = W'(1);
      end
      classify = a;
   endfunction

   always_comb begin
      ax = classify(in_data.start_x, in_data.end_x, win.xmin, win.xmax);
      ay = classify(in_data.start_y, in_data.end_y, win.ymin, win.ymax);
      task_in.rej = ax.rej || ay.rej;
      task_in.ex  = ax.enter;
      task_in.ey  = ay.enter;
      task_in.lx  = ax.leave;
      task_in.ly  = ay.leave;
      task_in.seg = in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      task_ff <= task_in;
   end

   assign out_valid = valid_ff;
   assign out_task  = task_ff;

endmodule

@@ rtl/rlc_queue.sv @@
// ----------------------------------------------------------------------------
// rlc_queue
// Two-entry queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module rlc_queue import rlc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_data,
   input  logic     pop,
   output logic     not_empty,
   output logic     full,
   output task_type pop_data
);

   localparam int DEPTH = 2;

   task_type   mem_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'(DEPTH));
   assign pop_data  = mem_ff[rd_ptr_ff];

endmodule

@@ rtl/rlc_back.sv @@
// ----------------------------------------------------------------------------
// rlc_back
// Picks the entering and leaving parameters, decides the status, forms the
// exact point numerators and divides them in a one-bit-per-stage pipeline.
// ----------------------------------------------------------------------------
module rlc_back import rlc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  task_type in_task,
   output logic     out_valid,
   output rsp_type  out_data
);

   localparam int W     = COORD_W;
   localparam int LANES = 4;

   typedef struct packed {
      logic [2*W-2:0] mag;
      logic [W-1:0]   div;
      logic           neg;
      logic [W-1:0]   rem;
      logic [W-1:0]   quo;
   } lane_type;

   typedef struct packed {
      logic [1:0] status;
      req_type    seg;
   } side_type;

   // Stage 1: chosen parameters.
   logic     s1_valid_ff;
   logic     s1_rej_ff;
   frac_type s1_en_ff;
   frac_type s1_ln_ff;
   req_type  s1_seg_ff;
   frac_type s1_en_in;
   frac_type s1_ln_in;

   // Stage 2: status and start-times-denominator products.
   logic              s2_valid_ff;
   side_type          s2_side_ff;
   frac_type          s2_en_ff;
   frac_type          s2_ln_ff;
   logic signed [2*W+1:0] s2_sd_ff [LANES];
   side_type          s2_side_in;

   // Stage 3 onward: lanes through the divider.
   logic     dv_valid_ff [W+1];
   side_type dv_side_ff  [W+1];
   lane_type dv_lane_ff  [W+1][LANES];
   lane_type s3_lane_in  [LANES];

   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   function automatic logic frac_gt(input frac_type a, input frac_type b);
      logic signed [2*W+1:0] pa;
      logic signed [2*W+1:0] pb;
      pa = a.n * $signed({1'b0, b.d});
      pb = b.n * $signed({1'b0, a.d});
      frac_gt = pa > pb;
   endfunction

   function automatic lane_type make_lane(input logic signed [2*W+1:0] sd,
                                          input frac_type f,
                                          input logic signed [W:0] delta);
      logic signed [2*W+1:0] nd;
      logic signed [2*W+2:0] sum;
      logic signed [2*W+2:0] mag;
      lane_type l;
      nd    = f.n * delta;
      sum   = {sd[2*W+1], sd} + {nd[2*W+1], nd};
      mag   = sum[2*W+2] ? -sum : sum;
      l.mag = mag[2*W-2:0];
      l.div = f.d;
      l.neg = sum[2*W+2];
      l.rem = {1'b0, mag[2*W-2:W]};
      l.quo = '0;
      make_lane = l;
   endfunction

   // Stage 1 selection: largest entering, smallest leaving.
   always_comb begin
      s1_en_in = frac_gt(in_task.ex, in_task.ey) ? in_task.ex : in_task.ey;
      s1_ln_in = frac_gt(in_task.ly, in_task.lx) ? in_task.lx : in_task.ly;
   end

   always_comb begin
      s2_side_in.seg = s1_seg_ff;
      if (s1_rej_ff) begin
         s2_side_in.status = ST_REJECT;
      end else if ((s1_en_ff.n == '0) && (s1_ln_ff.n == $signed({1'b0, s1_ln_ff.d}))) begin
         s2_side_in.status = ST_INSIDE;
      end else if (frac_gt(s1_ln_ff, s1_en_ff)) begin
         s2_side_in.status = ST_CLIPPED;
      end else begin
         s2_side_in.status = ST_REJECT;
      end
   end

   always_comb begin
      s3_lane_in[0] = make_lane(s2_sd_ff[0], s2_en_ff,
                                sext1(s2_side_ff.seg.end_x) - sext1(s2_side_ff.seg.start_x));
      s3_lane_in[1] = make_lane(s2_sd_ff[1], s2_en_ff,
                                sext1(s2_side_ff.seg.end_y) - sext1(s2_side_ff.seg.start_y));
      s3_lane_in[2] = make_lane(s2_sd_ff[2], s2_ln_ff,
                                sext1(s2_side_ff.seg.end_x) - sext1(s2_side_ff.seg.start_x));
      s3_lane_in[3] = make_lane(s2_sd_ff[3], s2_ln_ff,
                                sext1(s2_side_ff.seg.end_y) - sext1(s2_side_ff.seg.start_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else begin
         s1_valid_ff    <= in_valid;
         s2_valid_ff    <= s1_valid_ff;
         dv_valid_ff[0] <= s2_valid_ff;
      end
      s1_rej_ff   <= in_task.rej;
      s1_en_ff    <= s1_en_in;
      s1_ln_ff    <= s1_ln_in;
      s1_seg_ff   <= in_task.seg;
      s2_side_ff  <= s2_side_in;
      s2_en_ff    <= s1_en_ff;
      s2_ln_ff    <= s1_ln_ff;
      s2_sd_ff[0] <= s1_seg_ff.start_x * $signed({1'b0, s1_en_ff.d});
      s2_sd_ff[1] <= s1_seg_ff.start_y * $signed({1'b0, s1_en_ff.d});
      s2_sd_ff[2] <= s1_seg_ff.start_x * $signed({1'b0, s1_ln_ff.d});
      s2_sd_ff[3] <= s1_seg_ff.start_y * $signed({1'b0, s1_ln_ff.d});
      dv_side_ff[0] <= s2_side_ff;
      for (int i = 0; i < LANES; i++) begin
         dv_lane_ff[0][i] <= s3_lane_in[i];
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar s = 0; s < W; s++) begin : g_div
      lane_type nxt [LANES];

      always_comb begin
         for (int i = 0; i < LANES; i++) begin
            logic [W:0] trial;
            trial  = {dv_lane_ff[s][i].rem, dv_lane_ff[s][i].mag[W-1-s]};
            nxt[i] = dv_lane_ff[s][i];
            if (trial >= {1'b0, dv_lane_ff[s][i].div}) begin
               trial = trial - {1'b0, dv_lane_ff[s][i].div};
               nxt[i].quo = {dv_lane_ff[s][i].quo[W-2:0], 1'b1};
            end else begin
               nxt[i].quo = {dv_lane_ff[s][i].quo[W-2:0], 1'b0};
            end
            nxt[i].rem = trial[W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s+1] <= 1'b0;
         end else begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
         dv_side_ff[s+1] <= dv_side_ff[s];
         for (int i = 0; i < LANES; i++) begin
            dv_lane_ff[s+1][i] <= nxt[i];
         end
      end
   end

   always_comb begin
      coord_type pt [LANES];
      for (int i = 0; i < LANES; i++) begin
         pt[i] = dv_lane_ff[W][i].neg ? coord_type'(-dv_lane_ff[W][i].quo)
                                      : coord_type'(dv_lane_ff[W][i].quo);
      end
      out_data_in.clip_status = dv_side_ff[W].status;
      unique case (dv_side_ff[W].status)
         ST_INSIDE: begin
            out_data_in.clip_start_x = dv_side_ff[W].seg.start_x;
            out_data_in.clip_start_y = dv_side_ff[W].seg.start_y;
            out_data_in.clip_end_x   = dv_side_ff[W].seg.end_x;
            out_data_in.clip_end_y   = dv_side_ff[W].seg.end_y;
         end
         ST_CLIPPED: begin
            out_data_in.clip_start_x = pt[0];
            out_data_in.clip_start_y = pt[1];
            out_data_in.clip_end_x   = pt[2];
            out_data_in.clip_end_y   = pt[3];
         end
         default: begin
            out_data_in.clip_status  = ST_REJECT;
            out_data_in.clip_start_x = '0;
            out_data_in.clip_start_y = '0;
            out_data_in.clip_end_x   = '0;
            out_data_in.clip_end_y   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid_ff[W];
      end
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ rtl/rect_line_clipper.sv @@
// ----------------------------------------------------------------------------
// rect_line_clipper
// Clips one segment per cycle against an axis-aligned window.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Transfer
//   request   start, busy, req_data          start high and busy low
//   result    rsp_valid, rsp_data            one-cycle strobe, never held off
//   config    csr_we, csr_addr, csr_wdata    write enable high
//
// A new word is taken every cycle. Each result passes through the front
// register, the queue entry, three selection and product stages, twelve
// divider stages (one quotient bit per stage, set by the 12-bit coordinate
// width) and the output register.
// Reset clears all valid flags and loads the default window. Since the
// receiver cannot stall, the queue drains every cycle and busy stays low.
//
// The front classifies each word: it rejects a segment lying outside a slab
// it runs parallel to, and forms per axis the entering and leaving crossing
// parameters as exact fractions. The back picks the latest entering and the
// earliest leaving parameter, decides the status, and divides the exact
// rational end points, truncating toward zero.
// ----------------------------------------------------------------------------
module rect_line_clipper import rlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  coord_type         csr_wdata
);

   window_type win_ff;
   window_type win_in;
   logic       accept;
   logic       fr_valid;
   task_type   fr_task;
   logic       q_not_empty;
   logic       q_full;
   task_type   q_task;

   // Window registers; the user must write them only while the block is idle; the block does not enforce it.
   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_XMIN: win_in.xmin = csr_wdata;
            REG_XMAX: win_in.xmax = csr_wdata;
            REG_YMIN: win_in.ymin = csr_wdata;
            REG_YMAX: win_in.ymax = csr_wdata;
            default:  win_in = win_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.xmin <= RST_XMIN;
         win_ff.xmax <= RST_XMAX;
         win_ff.ymin <= RST_YMIN;
         win_ff.ymax <= RST_YMAX;
      end else begin
         win_ff <= win_in;
      end
   end

   assign busy   = q_full;
   assign accept = start && !busy;

   rlc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .win       (win_ff),
      .out_valid (fr_valid),
      .out_task  (fr_task)
   );

   rlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data (fr_task),
      .pop       (q_not_empty),
      .not_empty (q_not_empty),
      .full      (q_full),
      .pop_data  (q_task)
   );

   rlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_task   (q_task),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
